FILE: rtl/ptpq_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the periodic timer priority queue.
// No dependencies; the cell, chain and core files in rtl import this package.
package ptpq_pkg;

    localparam int NUM_TIMERS = 16;
    localparam int TIME_BITS  = 48;
    localparam int ID_BITS    = 4;
    localparam int KIND_BITS  = 2;
    localparam int IDX_W      = $clog2(NUM_TIMERS);
    localparam int CNT_W      = $clog2(NUM_TIMERS + 1);
    // At most this many timers fire on one advance.
    localparam int MAX_FIRE   = NUM_TIMERS;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_ADD     = 2'd0,
        KIND_CANCEL  = 2'd1,
        KIND_ADVANCE = 2'd2,
        KIND_NONE    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_REARM,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE
    } cell_op_t;

    typedef struct packed {
        logic                 valid;
        logic [TIME_BITS-1:0] expiry;
        logic [TIME_BITS-1:0] interval;
        logic [ID_BITS-1:0]   ident;
    } entry_t;

    // Command broadcast to every cell of the sorted row.
    typedef struct packed {
        cell_op_t             op;
        logic                 pop;
        logic [TIME_BITS-1:0] expiry;
        logic [TIME_BITS-1:0] interval;
        logic [ID_BITS-1:0]   ident;
    } chain_cmd_t;

    // Status the row reports back to the controller.
    typedef struct packed {
        entry_t head;
        logic   full;
        logic   new_first;
    } chain_stat_t;

endpackage

FILE: rtl/ptpq_cell.sv
`timescale 1ns / 1ps
// One slot of the sorted timer row: holds an entry and shifts it to either neighbour.
// Depends on ptpq_pkg.
module ptpq_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  ptpq_pkg::chain_cmd_t cmd,
    input  ptpq_pkg::entry_t    left_data,
    input  logic                left_keep,
    input  logic                left_rm,
    input  ptpq_pkg::entry_t    right_data,
    output ptpq_pkg::entry_t    data,
    output logic                keep,
    output logic                rm
);
    import ptpq_pkg::*;

    logic                 valid_reg, valid_next;
    logic [TIME_BITS-1:0] expiry_reg, expiry_next;
    logic [TIME_BITS-1:0] interval_reg, interval_next;
    logic [ID_BITS-1:0]   ident_reg, ident_next;

    // An entry stays put on insertion when it is due no later than the new one,
    // so equal times keep their order of arrival.
    assign keep = valid_reg && (expiry_reg <= cmd.expiry);
    assign rm   = left_rm || (valid_reg && !cmd.pop && (ident_reg == cmd.ident));
    assign data = '{valid: valid_reg, expiry: expiry_reg, interval: interval_reg,
                    ident: ident_reg};

    always_comb
    begin
        valid_next    = valid_reg;
        expiry_next   = expiry_reg;
        interval_next = interval_reg;
        ident_next    = ident_reg;
        unique case (cmd.op)
            CELL_HOLD:
            begin
            end
            CELL_INSERT:
            begin
                if (!keep)
                begin
                    if (left_keep)
                    begin
                        valid_next    = 1'b1;
                        expiry_next   = cmd.expiry;
                        interval_next = cmd.interval;
                        ident_next    = cmd.ident;
                    end
                    else
                    begin
                        valid_next    = left_data.valid;
                        expiry_next   = left_data.expiry;
                        interval_next = left_data.interval;
                        ident_next    = left_data.ident;
                    end
                end
            end
            CELL_REMOVE:
            begin
                if (rm)
                begin
                    valid_next    = right_data.valid;
                    expiry_next   = right_data.expiry;
                    interval_next = right_data.interval;
                    ident_next    = right_data.ident;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        expiry_reg   <= expiry_next;
        interval_reg <= interval_next;
        ident_reg    <= ident_next;
    end

endmodule

FILE: rtl/ptpq_chain.sv
`timescale 1ns / 1ps
// Row of NUM_TIMERS cells kept sorted by expiry, valid entries forming a prefix.
// Depends on ptpq_pkg and ptpq_cell.
module ptpq_chain (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ptpq_pkg::chain_cmd_t cmd,
    output ptpq_pkg::chain_stat_t stat
);
    import ptpq_pkg::*;

    entry_t cell_data [NUM_TIMERS];
    logic   cell_keep [NUM_TIMERS];
    logic   cell_rm   [NUM_TIMERS];

    genvar gi;
    generate
        for (gi = 0; gi < NUM_TIMERS; gi++)
        begin : g_cell
            entry_t left_d;
            entry_t right_d;
            logic   left_k;
            logic   left_r;

            if (gi == 0)
            begin : g_first
                // The head takes the new entry unless it is due no later.
                assign left_d = '0;
                assign left_k = 1'b1;
                assign left_r = cmd.pop;
            end
            else
            begin : g_mid
                assign left_d = cell_data[gi-1];
                assign left_k = cell_keep[gi-1];
                assign left_r = cell_rm[gi-1];
            end

            if (gi == NUM_TIMERS - 1)
            begin : g_last
                assign right_d = '0;
            end
            else
            begin : g_inner
                assign right_d = cell_data[gi+1];
            end

            ptpq_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cmd),
                .left_data  (left_d),
                .left_keep  (left_k),
                .left_rm    (left_r),
                .right_data (right_d),
                .data       (cell_data[gi]),
                .keep       (cell_keep[gi]),
                .rm         (cell_rm[gi])
            );
        end
    endgenerate

    assign stat.head      = cell_data[0];
    assign stat.full      = cell_data[NUM_TIMERS-1].valid;
    assign stat.new_first = !cell_keep[0];

endmodule

FILE: rtl/periodic_timer_priority_queue_core.sv
`timescale 1ns / 1ps
// Top level of the periodic timer priority queue: command control and fired-timer buffer.
// Depends on ptpq_pkg and ptpq_chain.
//
//  Channel  | Handshake              | Payload
//  ---------+------------------------+-----------------------------------------------
//  command  | start, busy            | kind, timer_id, expire_time, repeat_interval,
//           |                        | now_time
//  result   | result_valid (strobe)  | fired_valid, fired_id, became_first, full_error,
//           |                        | has_pending, next_deadline, last
//
// For add, cancel and unused kinds, any row update is made at the accepting edge and the
// single result follows in the next cycle. An advance that fires n timers pops them one per
// cycle off the head of the row, then takes one re-arm insertion slot per fired timer, then
// gives one result per cycle: one per fired timer, or a single result if none fired.
// Reset clears every valid bit at once; no clearing pass is needed.
// Results cannot be stalled; busy stays high until the last one has been transferred.
module periodic_timer_priority_queue_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [ptpq_pkg::KIND_BITS-1:0]     kind,
    input  logic [ptpq_pkg::ID_BITS-1:0]       timer_id,
    input  logic [ptpq_pkg::TIME_BITS-1:0]     expire_time,
    input  logic [ptpq_pkg::TIME_BITS-1:0]     repeat_interval,
    input  logic [ptpq_pkg::TIME_BITS-1:0]     now_time,
    output logic                               result_valid,
    output logic                               fired_valid,
    output logic [ptpq_pkg::ID_BITS-1:0]       fired_id,
    output logic                               became_first,
    output logic                               full_error,
    output logic                               has_pending,
    output logic [ptpq_pkg::TIME_BITS-1:0]     next_deadline,
    output logic                               last
);
    import ptpq_pkg::*;

    state_t               state_reg, state_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [CNT_W-1:0]     nf_reg, nf_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic                 bf_reg, bf_next;
    logic                 fe_reg, fe_next;
    logic [ID_BITS-1:0]   fid_reg  [MAX_FIRE];
    logic [TIME_BITS-1:0] fivl_reg [MAX_FIRE];

    chain_cmd_t           cmd;
    chain_stat_t          stat;
    logic                 accept;
    logic                 can_pop;
    logic                 rearm_done;
    logic                 emit_last;
    logic [TIME_BITS:0]   rearm_sum;
    logic [TIME_BITS-1:0] rearm_time;
    logic [ID_BITS-1:0]   cur_fid;
    logic [TIME_BITS-1:0] cur_fivl;
    logic                 fire_wr;

    ptpq_chain u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat)
    );

    assign busy       = (state_reg != ST_IDLE);
    assign accept     = start && !busy;
    assign can_pop    = stat.head.valid && (stat.head.expiry < now_reg)
                        && (nf_reg < CNT_W'(MAX_FIRE));
    assign rearm_done = (idx_reg == nf_reg);
    assign emit_last  = (nf_reg == '0) || (idx_reg == nf_reg - CNT_W'(1));
    assign cur_fid    = fid_reg[idx_reg[IDX_W-1:0]];
    assign cur_fivl   = fivl_reg[idx_reg[IDX_W-1:0]];

    // Re-arm time saturates at the top of the time range.
    assign rearm_sum  = {1'b0, now_reg} + {1'b0, cur_fivl};
    assign rearm_time = rearm_sum[TIME_BITS] ? '1 : rearm_sum[TIME_BITS-1:0];

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (kind_t'(kind) == KIND_ADVANCE)
                    begin
                        state_next = ST_POP;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_POP:
            begin
                if (!can_pop)
                begin
                    state_next = ST_REARM;
                end
            end
            ST_REARM:
            begin
                if (rearm_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath control and register next values.
    always_comb
    begin
        cmd      = '{op: CELL_HOLD, pop: 1'b0, expiry: expire_time,
                     interval: repeat_interval, ident: timer_id};
        now_next = now_reg;
        nf_next  = nf_reg;
        idx_next = idx_reg;
        bf_next  = bf_reg;
        fe_next  = fe_reg;
        fire_wr  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    nf_next  = '0;
                    idx_next = '0;
                    bf_next  = 1'b0;
                    fe_next  = 1'b0;
                    now_next = now_time;
                    unique case (kind_t'(kind))
                        KIND_ADD:
                        begin
                            if (stat.full)
                            begin
                                fe_next = 1'b1;
                            end
                            else
                            begin
                                cmd.op  = CELL_INSERT;
                                bf_next = stat.new_first;
                            end
                        end
                        KIND_CANCEL:
                        begin
                            cmd.op = CELL_REMOVE;
                        end
                        KIND_ADVANCE, KIND_NONE:
                        begin
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_POP:
            begin
                if (can_pop)
                begin
                    cmd.op  = CELL_REMOVE;
                    cmd.pop = 1'b1;
                    fire_wr = 1'b1;
                    nf_next = nf_reg + CNT_W'(1);
                end
                else
                begin
                    idx_next = '0;
                end
            end
            ST_REARM:
            begin
                if (rearm_done)
                begin
                    idx_next = '0;
                end
                else
                begin
                    // There is always room: each re-arm refills a slot freed by a pop.
                    if (cur_fivl != '0)
                    begin
                        cmd = '{op: CELL_INSERT, pop: 1'b0, expiry: rearm_time,
                                interval: cur_fivl, ident: cur_fid};
                    end
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            ST_EMIT:
            begin
                idx_next = idx_reg + CNT_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            nf_reg    <= '0;
            idx_reg   <= '0;
            bf_reg    <= 1'b0;
            fe_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            nf_reg    <= nf_next;
            idx_reg   <= idx_next;
            bf_reg    <= bf_next;
            fe_reg    <= fe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg <= now_next;
        if (fire_wr)
        begin
            fid_reg[nf_reg[IDX_W-1:0]]  <= stat.head.ident;
            fivl_reg[nf_reg[IDX_W-1:0]] <= stat.head.interval;
        end
    end

    // Result outputs; status reflects the row after the whole item.
    assign result_valid  = (state_reg == ST_EMIT);
    assign fired_valid   = result_valid && (nf_reg != '0);
    assign fired_id      = fired_valid ? cur_fid : '0;
    assign became_first  = result_valid && bf_reg;
    assign full_error    = result_valid && fe_reg;
    assign has_pending   = stat.head.valid;
    assign next_deadline = stat.head.valid ? stat.head.expiry : '0;
    assign last          = result_valid && emit_last;

endmodule

FILE: rtl/ptpq_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the periodic timer priority queue, bound to the top level.
// Depends on periodic_timer_priority_queue_core.
module ptpq_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic                               busy,
    input  logic                               result_valid,
    input  logic                               fired_valid,
    input  logic                               became_first,
    input  logic                               full_error,
    input  logic                               last
);

    // Every accepted command keeps the block busy until its results are out.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after a command transfer");

    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last |=> !busy)
        else $error("busy still high after the last result");

    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result strobe while idle");

    // A status-only result is always the single result of its command.
    a_quiet_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !fired_valid |-> last)
        else $error("non-firing result not marked last");

    a_full_excl: assert property (@(posedge clk) disable iff (!rst_n)
        full_error |-> result_valid && !became_first && !fired_valid)
        else $error("full error combined with another outcome");

endmodule

bind periodic_timer_priority_queue_core ptpq_checker u_ptpq_checker (.*);

FILE: bench/periodic_timer_priority_queue_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for periodic_timer_priority_queue_core: drives add, cancel and
// advance commands and checks every result strobe against a local sorted-list predictor.
// Depends on ptpq_pkg and the RTL of periodic_timer_priority_queue_core.
module periodic_timer_priority_queue_core_tb;

    import ptpq_pkg::*;

    typedef logic [TIME_BITS-1:0] tick_t;
    typedef logic [ID_BITS-1:0]   tid_t;

    typedef struct {
        kind_t kind;
        tid_t  id;
        tick_t exp;
        tick_t ivl;
        tick_t now;
    } timer_cmd_t;

    typedef struct {
        logic  fired_valid;
        tid_t  fired_id;
        logic  became_first;
        logic  full_error;
        logic  has_pending;
        tick_t next_deadline;
        logic  last;
    } timer_report_t;

    localparam tick_t TICK_MAX    = '1;
    localparam int    RANDOM_CMDS = 220;
    localparam int    QUIET_LIMIT = 3000;
    localparam int    TAIL_CYCLES = 40;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  start = 1'b0;
    logic  busy;
    logic [KIND_BITS-1:0] kind = KIND_NONE;
    tid_t  timer_id = '0;
    tick_t expire_time = '0;
    tick_t repeat_interval = '0;
    tick_t now_time = '0;
    logic  result_valid;
    logic  fired_valid;
    tid_t  fired_id;
    logic  became_first;
    logic  full_error;
    logic  has_pending;
    tick_t next_deadline;
    logic  last;

    // Predicted contents of the sorted timer list.
    tick_t sched_exp [NUM_TIMERS];
    tick_t sched_ivl [NUM_TIMERS];
    tid_t  sched_id  [NUM_TIMERS];
    int    sched_count = 0;

    timer_cmd_t    cmd_q[$];
    timer_report_t report_q[$];
    timer_cmd_t    held_cmd;
    timer_report_t mon_want;

    int gap_left = 0;
    int calm_left = 0;
    int quiet_cycles = 0;
    int errors = 0;
    int results_seen = 0;
    int fired_total = 0;
    int refused_total = 0;
    int kind_count [4] = '{0, 0, 0, 0};

    periodic_timer_priority_queue_core DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .kind            (kind),
        .timer_id        (timer_id),
        .expire_time     (expire_time),
        .repeat_interval (repeat_interval),
        .now_time        (now_time),
        .result_valid    (result_valid),
        .fired_valid     (fired_valid),
        .fired_id        (fired_id),
        .became_first    (became_first),
        .full_error      (full_error),
        .has_pending     (has_pending),
        .next_deadline   (next_deadline),
        .last            (last)
    );

    always #2 clk = ~clk;

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic tick_t rand_tick();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[TIME_BITS-1:0];
    endfunction

    function automatic void queue_cmd(kind_t k, tid_t id, tick_t exp, tick_t ivl, tick_t now);
        timer_cmd_t c;
        c.kind = k;
        c.id   = id;
        c.exp  = exp;
        c.ivl  = ivl;
        c.now  = now;
        cmd_q.insert(cmd_q.size(), c);
    endfunction

    // A new timer goes after every timer with the same expiration.
    function automatic logic sched_insert(tick_t t, tick_t ivl, tid_t id);
        int   pos;
        logic first;
        first = (sched_count == 0) || (t < sched_exp[0]);
        pos = 0;
        while (pos < sched_count && sched_exp[pos] <= t)
            pos++;
        for (int i = sched_count; i > pos; i--)
        begin
            sched_exp[i] = sched_exp[i-1];
            sched_ivl[i] = sched_ivl[i-1];
            sched_id[i]  = sched_id[i-1];
        end
        sched_exp[pos] = t;
        sched_ivl[pos] = ivl;
        sched_id[pos]  = id;
        sched_count++;
        return first;
    endfunction

    function automatic void sched_remove(int pos);
        for (int i = pos; i < sched_count - 1; i++)
        begin
            sched_exp[i] = sched_exp[i+1];
            sched_ivl[i] = sched_ivl[i+1];
            sched_id[i]  = sched_id[i+1];
        end
        sched_count--;
    endfunction

    function automatic void push_report(logic fv, tid_t fid, logic bf, logic fe, logic lst);
        timer_report_t r;
        r.fired_valid   = fv;
        r.fired_id      = fv ? fid : '0;
        r.became_first  = bf;
        r.full_error    = fe;
        r.has_pending   = (sched_count > 0);
        r.next_deadline = (sched_count > 0) ? sched_exp[0] : '0;
        r.last          = lst;
        report_q.insert(report_q.size(), r);
    endfunction

    // Applies one accepted command to the predicted list and queues the results it causes.
    function automatic void schedule_command(timer_cmd_t c);
        logic  first;
        logic  full;
        logic  found;
        int    nf;
        tid_t  fire_id  [MAX_FIRE];
        tick_t fire_ivl [MAX_FIRE];
        tick_t rearm;
        first = 1'b0;
        full  = 1'b0;
        found = 1'b0;
        nf    = 0;
        kind_count[c.kind]++;
        case (c.kind)
            KIND_ADD:
            begin
                if (sched_count >= NUM_TIMERS)
                begin
                    full = 1'b1;
                    refused_total++;
                end
                else
                    first = sched_insert(c.exp, c.ivl, c.id);
            end
            KIND_CANCEL:
            begin
                for (int i = 0; i < sched_count; i++)
                begin
                    if (!found && sched_id[i] == c.id)
                    begin
                        sched_remove(i);
                        found = 1'b1;
                    end
                end
            end
            KIND_ADVANCE:
            begin
                while (nf < MAX_FIRE && sched_count > 0 && sched_exp[0] < c.now)
                begin
                    fire_id[nf]  = sched_id[0];
                    fire_ivl[nf] = sched_ivl[0];
                    sched_remove(0);
                    nf++;
                end
                // Repeating timers re-arm at now plus interval, pinned at the top of the
                // time range when the sum would overflow.
                for (int i = 0; i < nf; i++)
                begin
                    if (fire_ivl[i] != '0 && sched_count < NUM_TIMERS)
                    begin
                        rearm = (fire_ivl[i] > ~c.now) ? TICK_MAX : c.now + fire_ivl[i];
                        void'(sched_insert(rearm, fire_ivl[i], fire_id[i]));
                    end
                end
            end
            default:
            begin
            end
        endcase
        fired_total += nf;
        if (nf == 0)
            push_report(1'b0, '0, first, full, 1'b1);
        else
            for (int i = 0; i < nf; i++)
                push_report(1'b1, fire_id[i], 1'b0, 1'b0, i == nf - 1);
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
            calm_left = $urandom_range(10, 30);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    task automatic report_mismatch(string msg);
        errors++;
        $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    task automatic check_field(string name, tick_t got, tick_t want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
    endtask

    // Command driver: a transfer happens on an edge with start high and busy low.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start           <= 1'b0;
            kind            <= KIND_NONE;
            timer_id        <= '0;
            expire_time     <= '0;
            repeat_interval <= '0;
            now_time        <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                schedule_command(held_cmd);
                gap_left = pick_gap();
            end
            if (!start || !busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (cmd_q.size() > 0)
                begin
                    held_cmd = cmd_q.pop_front();
                    start           <= 1'b1;
                    kind            <= held_cmd.kind;
                    timer_id        <= held_cmd.id;
                    expire_time     <= held_cmd.exp;
                    repeat_interval <= held_cmd.ivl;
                    now_time        <= held_cmd.now;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Result monitor: the strobe cannot be held off, so every strobed cycle is a transfer.
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            results_seen++;
            if (report_q.size() == 0)
                report_mismatch($sformatf("unexpected result, fired_valid %0b fired_id %0d",
                                          fired_valid, fired_id));
            else
            begin
                mon_want = report_q.pop_front();
                check_field("fired_valid", tick_t'(fired_valid),
                            tick_t'(mon_want.fired_valid));
                check_field("fired_id", tick_t'(fired_id), tick_t'(mon_want.fired_id));
                check_field("became_first", tick_t'(became_first),
                            tick_t'(mon_want.became_first));
                check_field("full_error", tick_t'(full_error),
                            tick_t'(mon_want.full_error));
                check_field("has_pending", tick_t'(has_pending),
                            tick_t'(mon_want.has_pending));
                check_field("next_deadline", next_deadline, mon_want.next_deadline);
                check_field("last", tick_t'(last), tick_t'(mon_want.last));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
                     quiet_cycles, report_q.size());
            $display("== FAIL ==");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        tick_t tbase;
        tick_t now;
        int    pick;

        // Directed: empty list, unknown id, unused kind, extremes, ties and duplicate ids.
        queue_cmd(KIND_ADVANCE, 4'd0, '0, '0, '0);
        queue_cmd(KIND_CANCEL, 4'd5, '0, '0, '0);
        queue_cmd(KIND_NONE, 4'd9, rand_tick(), rand_tick(), rand_tick());
        queue_cmd(KIND_ADD, 4'd15, TICK_MAX, TICK_MAX, '0);
        queue_cmd(KIND_ADD, 4'd0, '0, '0, TICK_MAX);
        queue_cmd(KIND_ADD, 4'd3, '0, tick_t'(5), '0);
        queue_cmd(KIND_ADD, 4'd3, tick_t'(40), '0, '0);
        queue_cmd(KIND_CANCEL, 4'd3, '0, '0, '0);
        queue_cmd(KIND_ADVANCE, 4'd0, '0, '0, '0);
        queue_cmd(KIND_ADVANCE, 4'd0, '0, '0, tick_t'(1));
        queue_cmd(KIND_CANCEL, 4'd15, '0, '0, '0);
        // Fill the list, try one add too many, then fire every entry in a single advance.
        for (int i = 0; i < NUM_TIMERS - 1; i++)
            queue_cmd(KIND_ADD, tid_t'(i), tick_t'(50 + (i % 5) * 40),
                      (i == 2) ? TICK_MAX : tick_t'((i % 2) * 7), '0);
        queue_cmd(KIND_ADD, 4'd9, tick_t'(60), '0, '0);
        queue_cmd(KIND_ADVANCE, 4'd0, '0, '0, tick_t'(300));
        queue_cmd(KIND_CANCEL, 4'd2, '0, '0, '0);

        // Random: mostly a moving time base with near-future timers, plus noise items
        // and the odd advance that steps back in time or jumps far ahead.
        tbase = tick_t'(400);
        for (int n = 0; n < RANDOM_CMDS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 2)
                queue_cmd(KIND_NONE, tid_t'($urandom_range(0, 15)), rand_tick(), rand_tick(),
                          rand_tick());
            else if (pick < 4)
                queue_cmd((pick == 2) ? KIND_ADD : KIND_CANCEL, tid_t'($urandom_range(0, 15)),
                          rand_tick(), rand_tick(), rand_tick());
            else if (pick < 42)
                queue_cmd(KIND_ADD, tid_t'($urandom_range(0, 15)),
                          tbase + tick_t'($urandom_range(0, 200)),
                          ($urandom_range(0, 3) == 0) ? tick_t'($urandom_range(1, 120)) : '0,
                          rand_tick());
            else if (pick < 64)
                queue_cmd(KIND_CANCEL, tid_t'($urandom_range(0, 15)), rand_tick(),
                          rand_tick(), rand_tick());
            else
            begin
                case ($urandom_range(0, 19))
                    0: now = tbase - tick_t'($urandom_range(0, 150));
                    1:
                    begin
                        tbase = tbase + tick_t'(2000);
                        now = tbase;
                    end
                    default:
                    begin
                        tbase = tbase + tick_t'($urandom_range(0, 150));
                        now = tbase;
                    end
                endcase
                queue_cmd(KIND_ADVANCE, tid_t'($urandom_range(0, 15)), rand_tick(),
                          rand_tick(), now);
            end
        end

        while (!rst_n || cmd_q.size() != 0 || start || report_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Commands: %0d add, %0d cancel, %0d advance, %0d unused kind.",
                 kind_count[KIND_ADD], kind_count[KIND_CANCEL], kind_count[KIND_ADVANCE],
                 kind_count[KIND_NONE]);
        $display("Results checked: %0d, timers fired: %0d, adds refused when full: %0d.",
                 results_seen, fired_total, refused_total);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
